// ----- src/mma_pkg.sv -----
package mma_pkg;

    // field widths fixed by the item format
    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int DIM_W   = 5;

    // default bound on the matrix dimension
    localparam int MAX_DIM_DEF = 16;
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    // operation codes
    localparam logic [OP_W-1:0] OP_WR_A = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_B = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_C = 3'd2;
    localparam logic [OP_W-1:0] OP_MAC  = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_C = 3'd4;

    // result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic mul;
        logic add;
    } t_cell_ctl;

endpackage

// ----- src/mma_cell.sv -----
module mma_cell (
    input  logic                                i_clk,
    input  mma_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [mma_pkg::ACC_W-1:0]    i_acc,
    input  logic signed [mma_pkg::ELEM_W-1:0]   i_a,
    input  logic signed [mma_pkg::ELEM_W-1:0]   i_b,
    output logic signed [mma_pkg::ACC_W-1:0]    o_acc
);

    logic signed [mma_pkg::PROD_W-1:0] r_prod;
    logic signed [mma_pkg::ACC_W-1:0]  r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
    end

    // accumulator: shift from neighbor or add product, wrapping
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_acc <= i_acc;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + mma_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- src/matrix_multiply_accumulate_top.sv -----
// Matrix multiply-accumulate, C += A * B over the top-left n x n corner,
// with n = min(dim, MAX_DIM). A read of C registers the stored value and then
// moves it into the result register, and holds off the next request while the
// read is pending. After reset a clearing pass zeroes C before requests are
// taken. A multiply runs row by row through a chain of MAX_DIM cells, one cell
// per column of C: for each row the C row is read and shifted into the chain,
// n products are accumulated with A broadcast and a B row read per cycle, and
// the row is shifted back out; at dim zero the result follows in the cycle after
// the request.
module matrix_multiply_accumulate_top #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mma_pkg::DIM_W-1:0]           i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mma_pkg::OP_W-1:0]            i_operation,
    input  logic [mma_pkg::POS_W-1:0]           i_row,
    input  logic [mma_pkg::POS_W-1:0]           i_col,
    input  logic signed [mma_pkg::ELEM_W-1:0]   i_element_value,
    input  logic signed [mma_pkg::ACC_W-1:0]    i_accumulator_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_kind,
    output logic signed [mma_pkg::ACC_W-1:0]    o_c_value
);

    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PW  = (IW > mma_pkg::POS_W) ? IW : mma_pkg::POS_W;
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int AW  = 2 * IW;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;

    typedef logic signed [MAX_DIM-1:0][mma_pkg::ELEM_W-1:0] t_brow;

    logic signed [mma_pkg::ELEM_W-1:0] a_mem [0:(2**AW)-1];
    t_brow                             b_mem [0:(2**IW)-1];
    logic signed [mma_pkg::ACC_W-1:0]  c_mem [0:(2**AW)-1];

    logic [2:0]                        r_state, n_state;
    logic [AW-1:0]                     r_clr;
    logic [mma_pkg::DIM_W-1:0]         r_dim;
    logic [CW-1:0]                     r_n;
    logic [IW-1:0]                     r_i, n_i;
    logic [IW-1:0]                     r_cnt, n_cnt;
    logic                              r_ld_v, r_v1, r_v2;
    logic                              r_rd_pend, r_rd_ok;
    logic                              r_out_valid, r_kind;
    logic signed [mma_pkg::ACC_W-1:0]  r_c_value;
    logic signed [mma_pkg::ACC_W-1:0]  r_c_rd;
    logic signed [mma_pkg::ELEM_W-1:0] r_a;
    t_brow                             r_brow;

    logic                              accept, pos_ok, done;
    logic [PW-1:0]                     row_w, col_w;
    logic [AW-1:0]                     in_addr, rd_addr, st_addr;
    logic [IW-1:0]                     nm1, col_rev;
    logic                              last_cnt, last_row;
    mma_pkg::t_cell_ctl                cell_ctl;
    logic signed [mma_pkg::ACC_W-1:0]  chain [0:MAX_DIM];

    // request decode
    assign accept  = i_in_valid && o_in_ready;
    assign row_w   = PW'(i_row);
    assign col_w   = PW'(i_col);
    assign pos_ok  = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign in_addr = {row_w[IW-1:0], col_w[IW-1:0]};
    assign o_in_ready = (r_state == ST_IDLE) && !r_rd_pend
                        && (!r_out_valid || i_out_ready);

    // sequencer indexes
    assign nm1      = IW'(r_n - CW'(1));
    assign col_rev  = nm1 - r_cnt;
    assign last_cnt = (r_cnt == nm1);
    assign last_row = (r_i == nm1);
    assign rd_addr  = (r_state == ST_LOAD) ? {r_i, col_rev} : in_addr;
    assign st_addr  = {r_i, col_rev};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= mma_pkg::DIM_RESET;
        end else if (i_cfg_wr_en) begin
            r_dim <= i_cfg_wr_data;
        end
    end

    // state machine
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_cnt   = r_cnt;
        done    = 1'b0;
        case (r_state)
            ST_CLR: begin
                if (&r_clr) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && i_operation == mma_pkg::OP_MAC) begin
                    n_i   = '0;
                    n_cnt = '0;
                    if (32'(r_dim) == 0) done = 1'b1;
                    else                 n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_cnt = r_cnt + IW'(1);
                if (last_cnt) begin
                    n_cnt   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                n_cnt = r_cnt + IW'(1);
                if (last_cnt) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) n_state = ST_STORE;
            end
            ST_STORE: begin
                n_cnt = r_cnt + IW'(1);
                if (last_cnt) begin
                    n_cnt = '0;
                    if (last_row) begin
                        done    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_ld_v  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= r_clr + AW'(1);
            r_ld_v  <= (r_state == ST_LOAD);
            r_v1    <= (r_state == ST_MAC);
            r_v2    <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_cnt <= n_cnt;
        if (accept && i_operation == mma_pkg::OP_MAC) begin
            r_n <= (32'(r_dim) > MAX_DIM) ? CW'(MAX_DIM) : CW'(r_dim);
        end
    end

    // a and b stores with registered reads
    always_ff @(posedge i_clk) begin
        if (accept && pos_ok && i_operation == mma_pkg::OP_WR_A) begin
            a_mem[in_addr] <= i_element_value;
        end
        r_a <= a_mem[{r_i, r_cnt}];
    end

    always_ff @(posedge i_clk) begin
        if (accept && pos_ok && i_operation == mma_pkg::OP_WR_B) begin
            b_mem[row_w[IW-1:0]][col_w[IW-1:0]] <= i_element_value;
        end
        r_brow <= b_mem[r_cnt];
    end

    // c store: clearing pass, row write-back, element writes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            c_mem[r_clr] <= '0;
        end else if (r_state == ST_STORE) begin
            c_mem[st_addr] <= chain[r_n];
        end else if (accept && pos_ok && i_operation == mma_pkg::OP_WR_C) begin
            c_mem[in_addr] <= i_accumulator_value;
        end
        r_c_rd <= c_mem[rd_addr];
    end

    // cell chain, one cell per column of c
    assign cell_ctl.shift = r_ld_v || (r_state == ST_STORE);
    assign cell_ctl.mul   = r_v1;
    assign cell_ctl.add   = r_v2;
    assign chain[0]       = (r_state == ST_STORE) ? '0 : r_c_rd;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        mma_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl),
            .i_acc (chain[j]),
            .i_a   (r_a),
            .i_b   (r_brow[j]),
            .o_acc (chain[j+1])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= accept && (i_operation == mma_pkg::OP_RD_C);
            if (r_rd_pend || done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= pos_ok;
        if (r_rd_pend) begin
            r_kind    <= mma_pkg::KIND_READ;
            r_c_value <= r_rd_ok ? r_c_rd : '0;
        end else if (done) begin
            r_kind    <= mma_pkg::KIND_DONE;
            r_c_value <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_c_value   = r_c_value;

    // a pending read always lands in the result register next cycle
    a_rd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ##1 (o_out_valid && o_kind == mma_pkg::KIND_READ))
        else $error("read request lost its result");

    // a finished result carries zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mma_pkg::KIND_DONE) |-> (o_c_value == '0))
        else $error("done result with nonzero value");

    // accumulation only while a multiply is in flight
    a_add_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == ST_MAC || r_state == ST_DRAIN))
        else $error("accumulate outside multiply");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int ELEM_W = mma_pkg::ELEM_W;
    localparam int ACC_W  = mma_pkg::ACC_W;
    localparam int PROD_W = mma_pkg::PROD_W;
    localparam int OP_W   = mma_pkg::OP_W;
    localparam int POS_W  = mma_pkg::POS_W;
    localparam int DIM_W  = mma_pkg::DIM_W;
    localparam logic [DIM_W-1:0] DIM_RESET = mma_pkg::DIM_RESET;
    localparam logic [OP_W-1:0] OP_WR_A = mma_pkg::OP_WR_A;
    localparam logic [OP_W-1:0] OP_WR_B = mma_pkg::OP_WR_B;
    localparam logic [OP_W-1:0] OP_WR_C = mma_pkg::OP_WR_C;
    localparam logic [OP_W-1:0] OP_MAC  = mma_pkg::OP_MAC;
    localparam logic [OP_W-1:0] OP_RD_C = mma_pkg::OP_RD_C;
    localparam logic KIND_DONE = mma_pkg::KIND_DONE;
    localparam logic KIND_READ = mma_pkg::KIND_READ;

    localparam int N_MAX         = mma_pkg::MAX_DIM_DEF;
    localparam int IDLE_WAIT     = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 6000;
    localparam int RAND_PER_SET  = 10;
    localparam logic [OP_W-1:0] OP_NONE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_NONE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE_HI  = 3'd7;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [DIM_W-1:0]         i_cfg_wr_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation;
    logic [POS_W-1:0]         i_row;
    logic [POS_W-1:0]         i_col;
    logic signed [ELEM_W-1:0] i_element_value;
    logic signed [ACC_W-1:0]  i_accumulator_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_kind;
    logic signed [ACC_W-1:0]  o_c_value;

    matrix_multiply_accumulate_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_row               (i_row),
        .i_col               (i_col),
        .i_element_value     (i_element_value),
        .i_accumulator_value (i_accumulator_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_c_value           (o_c_value)
    );

    // shadow copy of the matrices and the dimension register
    logic [ELEM_W-1:0] a_mat [N_MAX][N_MAX];
    logic [ELEM_W-1:0] b_mat [N_MAX][N_MAX];
    logic [ACC_W-1:0]  c_mat [N_MAX][N_MAX];
    bit                a_set [N_MAX][N_MAX];
    bit                b_set [N_MAX][N_MAX];
    logic [DIM_W-1:0]  dim_reg;

    // pending results
    logic             pend_kind [$];
    logic [ACC_W-1:0] pend_value [$];

    int errors;
    int n_reqs, n_macs, n_reads, n_results;
    int burst_left;
    int hold_cnt;
    int idle_cycles;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ELEM_W-1:0] ev;
        logic [ACC_W-1:0]  av;
        bit                typed;
        logic              t_kind;
        logic [ACC_W-1:0]  t_value;
    } t_row;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // multiply-accumulate over the active corner of the shadow matrices
    task automatic mac_update();
        int n;
        logic signed [PROD_W-1:0] p;
        logic [ACC_W-1:0] acc;
        n = (dim_reg > N_MAX) ? N_MAX : int'(dim_reg);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = c_mat[i][j];
                for (int k = 0; k < n; k++) begin
                    p = $signed(a_mat[i][k]) * $signed(b_mat[k][j]);
                    acc = acc + {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
                end
                c_mat[i][j] = acc;
            end
        end
    endtask

    // update the shadow state for one accepted request, return the result if any
    task automatic predict_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] r,
                               input logic [POS_W-1:0] c, input logic [ELEM_W-1:0] ev,
                               input logic [ACC_W-1:0] av, output bit has_res,
                               output logic kind, output logic [ACC_W-1:0] value);
        has_res = 1'b0;
        kind    = KIND_DONE;
        value   = '0;
        case (op)
            OP_WR_A: begin
                a_mat[r][c] = ev;
                a_set[r][c] = 1'b1;
            end
            OP_WR_B: begin
                b_mat[r][c] = ev;
                b_set[r][c] = 1'b1;
            end
            OP_WR_C: c_mat[r][c] = av;
            OP_MAC: begin
                mac_update();
                has_res = 1'b1;
            end
            OP_RD_C: begin
                has_res = 1'b1;
                kind    = KIND_READ;
                value   = c_mat[r][c];
            end
            default: ;
        endcase
    endtask

    // offer one request in bursts with random gaps, then record its outcome
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic [ELEM_W-1:0] ev,
                            input logic [ACC_W-1:0] av, input bit typed,
                            input logic t_kind, input logic [ACC_W-1:0] t_value);
        bit has_res;
        logic kind;
        logic [ACC_W-1:0] value;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid          <= 1'b1;
        i_operation         <= op;
        i_row               <= r;
        i_col               <= c;
        i_element_value     <= ev;
        i_accumulator_value <= av;
        do @(posedge i_clk); while (!o_in_ready);
        n_reqs++;
        predict_req(op, r, c, ev, av, has_res, kind, value);
        if (has_res) begin
            if (typed && (t_kind !== kind || t_value !== value)) begin
                $display("%0t: table row disagrees with predictor: table %0d/%h pred %0d/%h",
                         $time, t_kind, t_value, kind, value);
                errors++;
            end
            pend_kind.push_back(typed ? t_kind : kind);
            pend_value.push_back(typed ? t_value : value);
            if (op == OP_MAC) n_macs++;
            else n_reads++;
        end
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain();
        burst_left = 0;
        i_in_valid <= 1'b0;
        while (pend_kind.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_dim(input logic [DIM_W-1:0] d);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dim_reg = d;
        @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] rand_acc();
        case ($urandom_range(0, 7))
            0: return ACC_MAX;
            1: return ACC_MIN;
            2: return '0;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    // a multiply only ever sees written A and B entries
    task automatic fill_corner();
        int n;
        n = (dim_reg > N_MAX) ? N_MAX : int'(dim_reg);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!a_set[i][j])
                    send_req(OP_WR_A, POS_W'(i), POS_W'(j), rand_elem(), '0, 0, 0, '0);
                if (!b_set[i][j])
                    send_req(OP_WR_B, POS_W'(i), POS_W'(j), rand_elem(), '0, 0, 0, '0);
            end
        end
    endtask

    // one random request, mostly inside the active corner
    task automatic rand_req();
        int n, pick;
        logic [POS_W-1:0] r, c;
        n = (dim_reg > N_MAX) ? N_MAX : int'(dim_reg);
        if (n > 0 && $urandom_range(0, 3) != 0) begin
            r = POS_W'($urandom_range(0, n - 1));
            c = POS_W'($urandom_range(0, n - 1));
        end else begin
            r = POS_W'($urandom);
            c = POS_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_req(OP_WR_A, r, c, rand_elem(), rand_acc(), 0, 0, '0);
        else if (pick < 52)
            send_req(OP_WR_B, r, c, rand_elem(), rand_acc(), 0, 0, '0);
        else if (pick < 62)
            send_req(OP_WR_C, r, c, rand_elem(), rand_acc(), 0, 0, '0);
        else if (pick < 87)
            send_req(OP_RD_C, r, c, rand_elem(), rand_acc(), 0, 0, '0);
        else if (pick < 95) begin
            fill_corner();
            send_req(OP_MAC, r, c, rand_elem(), rand_acc(), 0, 0, '0);
        end else
            send_req(OP_WR_A + OP_W'($urandom_range(OP_NONE_LO, OP_NONE_HI)), r, c,
                     rand_elem(), rand_acc(), 0, 0, '0);
    endtask

    // result side: check each accepted result, stall on a pattern of its own
    initial begin
        int mode, mode_left;
        i_out_ready = 1'b0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pend_kind.size() == 0) begin
                    $display("%0t: unexpected result kind %0d value %h", $time, o_kind,
                             o_c_value);
                    errors++;
                end else begin
                    if (o_kind !== pend_kind[0]) begin
                        $display("%0t: kind mismatch expected %0d actual %0d", $time,
                                 pend_kind[0], o_kind);
                        errors++;
                    end
                    if (o_c_value !== pend_value[0]) begin
                        $display("%0t: c_value mismatch expected %h actual %h", $time,
                                 pend_value[0], o_c_value);
                        errors++;
                    end
                    void'(pend_kind.pop_front());
                    void'(pend_value.pop_front());
                end
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_row dir_rows [$];
        logic [DIM_W-1:0] dim_sets [] = '{5'd0, 5'd2, 5'd16, 5'd3, 5'd31, 5'd5,
                                          5'd17, 5'd1, 5'd4, 5'd8};
        errors = 0;
        n_reqs = 0;
        n_macs = 0;
        n_reads = 0;
        n_results = 0;
        burst_left = 0;
        hold_cnt = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_operation = OP_WR_A;
        i_row = '0;
        i_col = '0;
        i_element_value = '0;
        i_accumulator_value = '0;
        for (int i = 0; i < N_MAX; i++) begin
            for (int j = 0; j < N_MAX; j++) begin
                a_mat[i][j] = '0;
                b_mat[i][j] = '0;
                c_mat[i][j] = '0;
                a_set[i][j] = 1'b0;
                b_set[i][j] = 1'b0;
            end
        end
        dim_reg = DIM_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: cleared C, extremes, wrap, unknown operations
        dir_rows = '{
            '{OP_RD_C, 4'd0,  4'd0,  16'h0,    48'h0,   1, KIND_READ, 48'h0},
            '{OP_RD_C, 4'd15, 4'd15, 16'h0,    48'h0,   1, KIND_READ, 48'h0},
            '{OP_WR_C, 4'd15, 4'd15, 16'h0,    ACC_MAX, 0, 0,         48'h0},
            '{OP_RD_C, 4'd15, 4'd15, 16'h0,    48'h0,   1, KIND_READ, ACC_MAX},
            '{OP_WR_C, 4'd0,  4'd15, 16'h0,    ACC_MIN, 0, 0,         48'h0},
            '{OP_RD_C, 4'd0,  4'd15, 16'h0,    48'h0,   1, KIND_READ, ACC_MIN},
            '{OP_WR_A, 4'd0,  4'd0,  16'h8000, 48'h0,   0, 0,         48'h0},
            '{OP_WR_B, 4'd0,  4'd0,  16'h8000, 48'h0,   0, 0,         48'h0},
            '{OP_MAC,  4'd0,  4'd0,  16'h0,    48'h0,   1, KIND_DONE, 48'h0},
            '{OP_RD_C, 4'd0,  4'd0,  16'h0,    48'h0,   1, KIND_READ, 48'h0000_4000_0000},
            '{OP_WR_C, 4'd0,  4'd0,  16'h0,    ACC_MAX, 0, 0,         48'h0},
            '{OP_MAC,  4'd9,  4'd3,  16'hffff, ACC_MAX, 1, KIND_DONE, 48'h0},
            '{OP_RD_C, 4'd0,  4'd0,  16'h0,    48'h0,   0, 0,         48'h0},
            '{OP_WR_A, 4'd15, 4'd15, 16'h7fff, 48'h0,   0, 0,         48'h0},
            '{OP_WR_B, 4'd0,  4'd0,  16'h7fff, 48'h0,   0, 0,         48'h0},
            '{OP_MAC,  4'd0,  4'd0,  16'h0,    48'h0,   1, KIND_DONE, 48'h0},
            '{OP_RD_C, 4'd0,  4'd0,  16'h0,    48'h0,   0, 0,         48'h0},
            '{OP_RD_C, 4'd15, 4'd15, 16'h0,    48'h0,   1, KIND_READ, ACC_MAX},
            '{OP_NONE_LO, 4'd0, 4'd0, 16'hffff, ACC_MAX, 0, 0,       48'h0},
            '{OP_NONE_MID, 4'd1, 4'd2, 16'h1234, ACC_MIN, 0, 0,       48'h0},
            '{OP_NONE_HI, 4'd15, 4'd15, 16'h8000, 48'h1, 0, 0,        48'h0},
            '{OP_RD_C, 4'd0,  4'd15, 16'h0,    48'h0,   1, KIND_READ, ACC_MIN}
        };
        write_dim(5'd1);
        foreach (dir_rows[i])
            send_req(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].ev,
                     dir_rows[i].av, dir_rows[i].typed, dir_rows[i].t_kind,
                     dir_rows[i].t_value);
        drain();

        // random phases over several dimension settings, each closed by a multiply
        foreach (dim_sets[s]) begin
            write_dim(dim_sets[s]);
            if (s == 3) begin
                // receiver holds off while reads pile up behind it
                hold_cnt = HOLD_CYCLES;
                repeat (24)
                    send_req(OP_RD_C, POS_W'($urandom), POS_W'($urandom), '0, '0,
                             0, 0, '0);
            end
            repeat (RAND_PER_SET) rand_req();
            fill_corner();
            send_req(OP_MAC, '0, '0, '0, '0, 0, 0, '0);
            drain();
        end

        repeat (IDLE_WAIT) @(posedge i_clk);
        $display("requests %0d, multiplies %0d, reads %0d, results checked %0d",
                 n_reqs, n_macs, n_reads, n_results);
        $display("dimensions 0 to 31 exercised, with wrap, extremes and stalls");
        if (errors == 0 && pend_kind.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
